[sv/psd_pkg.sv]
`default_nettype none

package psd_pkg;

   // coordinate and arithmetic widths
   localparam int COORD_BITS = 24;
   localparam int DIFF_W     = COORD_BITS + 1;   // P-S, E-S
   localparam int PROD_W     = 2 * DIFF_W;       // one signed product
   localparam int DOT_W      = PROD_W + 1;       // sum of two products
   localparam int LEN_W      = PROD_W;           // |E-S|^2, divider operands
   localparam int REM_W      = LEN_W + 2;        // divider partial remainder
   localparam int Q_W        = DIFF_W;           // |offset| <= |E-S|
   localparam int DIV_STAGES = Q_W;              // one quotient bit per stage
   localparam int OFS_W      = DIFF_W + 2;       // P minus nearest point
   localparam int SQ_W       = 2 * OFS_W;
   localparam int DSUM_W     = SQ_W + 1;

   localparam int THR_W  = 24;
   localparam int THR2_W = 2 * THR_W;
   localparam int DIST_W = 50;
   localparam logic [DIST_W-1:0] DIST_MAX = {1'b1, {(DIST_W-1){1'b0}}};

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_THRESHOLD = '0;

   typedef enum logic [1:0] {
      CASE_START    = 2'd0,
      CASE_END      = 2'd1,
      CASE_INTERIOR = 2'd2
   } psd_case_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } psd_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] dist_squared;
      logic              is_near;
      logic [1:0]        nearest_case;
   } psd_rsp_type;

   // geometry that rides along with the divider
   typedef struct packed {
      psd_case_type             kind;
      logic signed [DIFF_W-1:0] ax;
      logic signed [DIFF_W-1:0] ay;
      logic signed [DIFF_W-1:0] cx;
      logic signed [DIFF_W-1:0] cy;
   } psd_geom_type;

   typedef struct packed {
      psd_geom_type     geom;
      logic [LEN_W-1:0] num;
      logic [LEN_W-1:0] den;
      logic [Q_W-1:0]   cx_mag;
      logic [Q_W-1:0]   cy_mag;
   } psd_front_type;

   typedef struct packed {
      psd_geom_type   geom;
      logic [Q_W-1:0] qx;
      logic [Q_W-1:0] qy;
   } psd_quot_type;

endpackage

`default_nettype wire

[sv/psd_csr.sv]
`default_nettype none

module psd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [psd_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [psd_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [psd_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready,
   output logic [psd_pkg::THR2_W-1:0]            thr2
);
   import psd_pkg::*;

   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [THR2_W-1:0]    thr2_ff, thr2_in;
   logic [CSR_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      thr_in = thr_ff;
      if (psel && penable && pwrite && pready && reg_idx == REG_NEAR_THRESHOLD) begin
         thr_in = pwdata[THR_W-1:0];
      end
      // threshold squared, registered off the compare path
      thr2_in = THR2_W'(thr_ff) * THR2_W'(thr_ff);
   end

   always_comb begin
      unique case (reg_idx)
         REG_NEAR_THRESHOLD: prdata = CSR_DATA_W'(thr_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= '0;
         thr2_ff <= '0;
      end else begin
         thr_ff  <= thr_in;
         thr2_ff <= thr2_in;
      end
   end

   assign thr2 = thr2_ff;

endmodule

`default_nettype wire

[sv/psd_front.sv]
`default_nettype none

module psd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  psd_pkg::psd_req_type    in_data,
   output logic                    out_valid,
   output psd_pkg::psd_front_type  out_data
);
   import psd_pkg::*;

   typedef struct packed {
      logic signed [DIFF_W-1:0] ax;
      logic signed [DIFF_W-1:0] ay;
      logic signed [DIFF_W-1:0] cx;
      logic signed [DIFF_W-1:0] cy;
   } diff_type;

   typedef struct packed {
      diff_type                 d;
      logic signed [PROD_W-1:0] p_acx;
      logic signed [PROD_W-1:0] p_acy;
      logic signed [PROD_W-1:0] p_cxx;
      logic signed [PROD_W-1:0] p_cyy;
   } prod_type;

   typedef struct packed {
      diff_type                d;
      logic signed [DOT_W-1:0] dot;
      logic [LEN_W-1:0]        len2;
   } sum_type;

   diff_type      s1_in, s1_ff;
   prod_type      s2_in, s2_ff;
   sum_type       s3_in, s3_ff;
   psd_front_type s4_in, s4_ff;
   logic [3:0]    v_in, v_ff;

   // stage 1: A = P - S, C = E - S
   always_comb begin
      s1_in.ax = DIFF_W'($signed(in_data.point_x)) - DIFF_W'($signed(in_data.start_x));
      s1_in.ay = DIFF_W'($signed(in_data.point_y)) - DIFF_W'($signed(in_data.start_y));
      s1_in.cx = DIFF_W'($signed(in_data.end_x)) - DIFF_W'($signed(in_data.start_x));
      s1_in.cy = DIFF_W'($signed(in_data.end_y)) - DIFF_W'($signed(in_data.start_y));
   end

   // stage 2: four products
   always_comb begin
      s2_in.d     = s1_ff;
      s2_in.p_acx = $signed(s1_ff.ax) * $signed(s1_ff.cx);
      s2_in.p_acy = $signed(s1_ff.ay) * $signed(s1_ff.cy);
      s2_in.p_cxx = $signed(s1_ff.cx) * $signed(s1_ff.cx);
      s2_in.p_cyy = $signed(s1_ff.cy) * $signed(s1_ff.cy);
   end

   // stage 3: dot and len2
   always_comb begin
      s3_in.d    = s2_ff.d;
      s3_in.dot  = DOT_W'($signed(s2_ff.p_acx)) + DOT_W'($signed(s2_ff.p_acy));
      s3_in.len2 = $unsigned(s2_ff.p_cxx) + $unsigned(s2_ff.p_cyy);
   end

   // stage 4: pick the nearest-point case, set up divider operands
   always_comb begin
      logic dot_neg;
      dot_neg = s3_ff.dot[DOT_W-1];
      s4_in.geom.ax = s3_ff.d.ax;
      s4_in.geom.ay = s3_ff.d.ay;
      s4_in.geom.cx = s3_ff.d.cx;
      s4_in.geom.cy = s3_ff.d.cy;
      if (s3_ff.len2 == '0 || dot_neg) begin
         s4_in.geom.kind = CASE_START;
      end else if (s3_ff.dot[DOT_W-2:0] > s3_ff.len2) begin
         s4_in.geom.kind = CASE_END;
      end else begin
         s4_in.geom.kind = CASE_INTERIOR;
      end
      s4_in.num    = s3_ff.dot[LEN_W-1:0];
      s4_in.den    = s3_ff.len2;
      s4_in.cx_mag = s3_ff.d.cx[DIFF_W-1] ? Q_W'(-s3_ff.d.cx) : Q_W'(s3_ff.d.cx);
      s4_in.cy_mag = s3_ff.d.cy[DIFF_W-1] ? Q_W'(-s3_ff.d.cy) : Q_W'(s3_ff.d.cy);
   end

   always_comb begin
      v_in = v_ff;
      if (advance) begin
         v_in = {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v_ff[3];
   assign out_data  = s4_ff;

endmodule

`default_nettype wire

[sv/psd_div.sv]
`default_nettype none

// Pipelined restoring divider, two lanes: q = floor(num * c_mag / den),
// c_mag consumed MSB first, one bit per stage.
module psd_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  psd_pkg::psd_front_type  in_data,
   output logic                    out_valid,
   output psd_pkg::psd_quot_type   out_data
);
   import psd_pkg::*;

   typedef struct packed {
      logic [LEN_W-1:0] rem;
      logic [Q_W-1:0]   quot;
   } lane_type;

   typedef struct packed {
      psd_front_type op;
      lane_type      lx;
      lane_type      ly;
   } stage_type;

   // rem' = (2*rem + bit*num) mod den, quot' = 2*quot + floor(...)
   function automatic lane_type lane_step(lane_type cur, logic c_bit,
                                          logic [LEN_W-1:0] num,
                                          logic [LEN_W-1:0] den);
      logic [REM_W-1:0] t;
      logic [REM_W-1:0] den1;
      logic [REM_W-1:0] den2;
      logic [1:0]       inc;
      lane_type         nxt;
      t    = {1'b0, cur.rem, 1'b0} + (c_bit ? REM_W'(num) : '0);
      den1 = REM_W'(den);
      den2 = {1'b0, den, 1'b0};
      if (t >= den2) begin
         inc     = 2'd2;
         nxt.rem = LEN_W'(t - den2);
      end else if (t >= den1) begin
         inc     = 2'd1;
         nxt.rem = LEN_W'(t - den1);
      end else begin
         inc     = 2'd0;
         nxt.rem = LEN_W'(t);
      end
      nxt.quot = {cur.quot[Q_W-2:0], 1'b0} + Q_W'(inc);
      return nxt;
   endfunction

   stage_type             src   [DIV_STAGES];
   stage_type             st_in [DIV_STAGES];
   stage_type             st_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] src_v;
   logic [DIV_STAGES-1:0] v_in, v_ff;

   always_comb begin
      src[0].op = in_data;
      src[0].lx = '0;
      src[0].ly = '0;
      src_v[0]  = in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
         src[k]   = st_ff[k-1];
         src_v[k] = v_ff[k-1];
      end
   end

   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         st_in[k].op = src[k].op;
         st_in[k].lx = lane_step(src[k].lx, src[k].op.cx_mag[Q_W-1-k],
                                 src[k].op.num, src[k].op.den);
         st_in[k].ly = lane_step(src[k].ly, src[k].op.cy_mag[Q_W-1-k],
                                 src[k].op.num, src[k].op.den);
      end
   end

   always_comb begin
      v_in = v_ff;
      if (advance) begin
         v_in = src_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid     = v_ff[DIV_STAGES-1];
   assign out_data.geom = st_ff[DIV_STAGES-1].op.geom;
   assign out_data.qx   = st_ff[DIV_STAGES-1].lx.quot;
   assign out_data.qy   = st_ff[DIV_STAGES-1].ly.quot;

endmodule

`default_nettype wire

[sv/psd_back.sv]
`default_nettype none

module psd_back (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         advance,
   input  logic                         in_valid,
   input  psd_pkg::psd_quot_type        in_data,
   input  logic [psd_pkg::THR2_W-1:0]   thr2,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output psd_pkg::psd_rsp_type         rsp_data
);
   import psd_pkg::*;

   typedef struct packed {
      psd_case_type            kind;
      logic signed [OFS_W-1:0] dx;
      logic signed [OFS_W-1:0] dy;
   } ofs_type;

   typedef struct packed {
      psd_case_type           kind;
      logic signed [SQ_W-1:0] x2;
      logic signed [SQ_W-1:0] y2;
   } sq_type;

   typedef struct packed {
      psd_case_type      kind;
      logic [DSUM_W-1:0] sum;
   } dsum_type;

   ofs_type     b1_in, b1_ff;
   sq_type      b2_in, b2_ff;
   dsum_type    b3_in, b3_ff;
   logic [2:0]  v_in, v_ff;
   psd_rsp_type res;
   psd_rsp_type out_in, out_ff, skid_in, skid_ff;
   logic        out_v_in, out_v_ff, skid_v_in, skid_v_ff;
   logic        take, push;

   // stage 1: P minus the nearest segment point
   always_comb begin
      logic signed [OFS_W-1:0] ox, oy, subx, suby;
      ox = $signed({2'b00, in_data.qx});
      oy = $signed({2'b00, in_data.qy});
      if (in_data.geom.cx[DIFF_W-1]) ox = -ox;
      if (in_data.geom.cy[DIFF_W-1]) oy = -oy;
      case (in_data.geom.kind)
         CASE_START: begin
            subx = '0;
            suby = '0;
         end
         CASE_END: begin
            subx = OFS_W'($signed(in_data.geom.cx));
            suby = OFS_W'($signed(in_data.geom.cy));
         end
         default: begin
            subx = ox;
            suby = oy;
         end
      endcase
      b1_in.kind = in_data.geom.kind;
      b1_in.dx   = OFS_W'($signed(in_data.geom.ax)) - subx;
      b1_in.dy   = OFS_W'($signed(in_data.geom.ay)) - suby;
   end

   // stage 2: squares
   always_comb begin
      b2_in.kind = b1_ff.kind;
      b2_in.x2   = $signed(b1_ff.dx) * $signed(b1_ff.dx);
      b2_in.y2   = $signed(b1_ff.dy) * $signed(b1_ff.dy);
   end

   // stage 3: sum of squares
   always_comb begin
      b3_in.kind = b2_ff.kind;
      b3_in.sum  = DSUM_W'($unsigned(b2_ff.x2)) + DSUM_W'($unsigned(b2_ff.y2));
   end

   // result: saturate for the output, compare the full value
   always_comb begin
      res.dist_squared = (b3_ff.sum > DSUM_W'(DIST_MAX)) ? DIST_MAX
                                                          : b3_ff.sum[DIST_W-1:0];
      res.is_near      = (b3_ff.sum < DSUM_W'(thr2));
      res.nearest_case = b3_ff.kind;
   end

   assign advance = !skid_v_ff;
   assign take    = out_v_ff && rsp_ready;
   assign push    = advance && v_ff[2];

   always_comb begin
      v_in = v_ff;
      if (advance) begin
         v_in = {v_ff[1:0], in_valid};
      end
   end

   // output register plus skid slot
   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (take) begin
         out_v_in  = skid_v_ff;
         out_in    = skid_ff;
         skid_v_in = 1'b0;
      end
      if (push) begin
         if (!out_v_in) begin
            out_v_in = 1'b1;
            out_in   = res;
         end else begin
            skid_v_in = 1'b1;
            skid_in   = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         v_ff      <= v_in;
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_ff <= b1_in;
         b2_ff <= b2_in;
         b3_ff <= b3_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

[sv/point_segment_distance_top.sv]
// Point-to-segment squared distance, fully pipelined. Each req transaction
// carries a query point P and a segment S..E (signed 24-bit decimetre
// coordinates); each rsp transaction returns the squared distance from P to
// the nearest point of the segment (saturated at 2^49), whether that distance
// is below near_threshold squared, and which case applied (start endpoint,
// end endpoint or interior projection). The block takes one transaction per
// clock while the pipeline is not stalled and returns results in order. A
// transaction passes through differences, products and classification, the
// restoring divider that forms the interior offset one quotient bit per
// stage, then offset, squaring and summing, and finally the output register.
// The output register has a skid slot behind it, so req_ready stays high
// while a result waits and drops only once a second finished result is
// parked. near_threshold sits at byte address 0 of the register port and is
// to be written only while no transaction is in flight.
`default_nettype none

module point_segment_distance_top (
   input  logic                              clock,
   input  logic                              reset,

   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  psd_pkg::psd_req_type              req_data,

   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output psd_pkg::psd_rsp_type              rsp_data,

   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [psd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [psd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [psd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import psd_pkg::*;

   // one enable for every pipeline stage; low only while the skid is full
   logic          advance;
   logic [THR2_W-1:0] thr2;

   logic          front_valid;
   psd_front_type front_data;
   logic          div_valid;
   psd_quot_type  div_data;

   // a req transaction is taken whenever the pipeline moves
   assign req_ready = advance;

   psd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .thr2    (thr2)
   );

   // A = P-S, C = E-S, dot and len2, nearest-point case
   psd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // floor(dot * |C| / len2) per axis
   psd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // distance, threshold compare, output register and skid
   psd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_data   (div_data),
      .thr2      (thr2),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
